FILE: rtl/imu_tilt_kalman_filter_top_macros.svh
// Assertion helpers for the tilt filter, sampled on clk and quiet during reset.
`ifndef IMU_TILT_KALMAN_FILTER_TOP_MACROS_SVH
`define IMU_TILT_KALMAN_FILTER_TOP_MACROS_SVH

// Same-cycle implication
`define ITKF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ITKF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/itkf_pkg.sv
`timescale 1ns / 1ps
package itkf_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // CORDIC angle precision and table length
  localparam int ANG_FRAC = 24;
  localparam int TAB_LEN  = 24;
  localparam int TAB_IW   = 5;

  // Shared widths
  localparam int DEN_W  = 33;
  localparam int MEAS_W = 34;
  localparam int REG_W  = 24;
  localparam int IDX_W  = 8;
  localparam int DATA_W = 32;

  // Gyro scaling: 32.8 counts per deg/s over milliseconds
  localparam int GYRO_DIV  = 32800;
  localparam int GYRO_HALF = 16400;

  // Register indexes
  localparam int REG_Q_ROLL  = 0;
  localparam int REG_R_ROLL  = 1;
  localparam int REG_Q_PITCH = 2;
  localparam int REG_R_PITCH = 3;

  localparam logic [REG_W-1:0] Q_RESET = 24'd32768;
  localparam logic [REG_W-1:0] R_RESET = 24'd1966080;

  // atan(2^-i) in degrees with ANG_FRAC fraction bits
  function automatic logic [29:0] atan_deg(input logic [TAB_IW-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd754974720;
      5'd1:  v = 30'd445687602;
      5'd2:  v = 30'd235489088;
      5'd3:  v = 30'd119537938;
      5'd4:  v = 30'd60000934;
      5'd5:  v = 30'd30029717;
      5'd6:  v = 30'd15018523;
      5'd7:  v = 30'd7509720;
      5'd8:  v = 30'd3754917;
      5'd9:  v = 30'd1877466;
      5'd10: v = 30'd938734;
      5'd11: v = 30'd469367;
      5'd12: v = 30'd234684;
      5'd13: v = 30'd117342;
      5'd14: v = 30'd58671;
      5'd15: v = 30'd29335;
      5'd16: v = 30'd14668;
      5'd17: v = 30'd7334;
      5'd18: v = 30'd3667;
      5'd19: v = 30'd1833;
      5'd20: v = 30'd917;
      5'd21: v = 30'd458;
      5'd22: v = 30'd229;
      5'd23: v = 30'd115;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Saturate to the signed 32-bit range
  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: rtl/itkf_sdiv.sv
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle.
module itkf_sdiv #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt, den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W:0]   rem_sh;

  // Shift in one numerator bit, subtract when it fits
  always_comb begin
    rem_sh   = {rem_r, quo_r[NUM_W-1]};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(rem_sh - {1'b0, den_r});
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
      if (cnt_r == CNT_W'(NUM_W - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

FILE: rtl/itkf_cordic.sv
`timescale 1ns / 1ps
// Vectoring CORDIC atan2 in degrees, one rotation per cycle.
module itkf_cordic #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [16:0]                  y_in,
  input  logic signed [16:0]                  x_in,
  output logic                                busy,
  output logic signed [itkf_pkg::MEAS_W-1:0]  angle
);

  localparam int X_W   = 36;
  localparam int ACC_W = 34;
  localparam int N     = (CORDIC_STEPS < itkf_pkg::TAB_LEN) ? CORDIC_STEPS
                                                            : itkf_pkg::TAB_LEN;
  localparam int SH    = itkf_pkg::ANG_FRAC - FRAC_BITS;
  localparam logic signed [ACC_W-1:0] QUARTER =
    ACC_W'(longint'(90) << itkf_pkg::ANG_FRAC);
  localparam logic signed [ACC_W:0] HALF = (ACC_W+1)'((longint'(1) << SH) >> 1);

  logic signed [X_W-1:0]   x_r, x_nxt, y_r, y_nxt, xs, ys, dx, dy;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, tab;
  logic [itkf_pkg::TAB_IW-1:0] i_r, i_nxt;
  logic                    busy_r, busy_nxt, zero_r, zero_nxt;
  logic signed [ACC_W:0]   acc_rnd;

  always_comb begin
    xs       = X_W'(x_in) <<< 16;
    ys       = X_W'(y_in) <<< 16;
    dx       = y_r >>> i_r;
    dy       = x_r >>> i_r;
    tab      = ACC_W'(itkf_pkg::atan_deg(i_r));
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    i_nxt    = i_r;
    busy_nxt = busy_r;
    zero_nxt = zero_r;
    if (start) begin
      // Load and turn the left half-plane by a quarter
      zero_nxt = (x_in == '0) && (y_in == '0);
      i_nxt    = '0;
      busy_nxt = 1'b1;
      if (xs < 0) begin
        if (ys >= 0) begin
          acc_nxt = QUARTER;
          x_nxt   = ys;
          y_nxt   = -xs;
        end else begin
          acc_nxt = -QUARTER;
          x_nxt   = -ys;
          y_nxt   = xs;
        end
      end else begin
        acc_nxt = '0;
        x_nxt   = xs;
        y_nxt   = ys;
      end
    end else if (busy_r) begin
      // Rotate toward the x axis
      if (y_r >= 0) begin
        x_nxt   = x_r + dx;
        y_nxt   = y_r - dy;
        acc_nxt = acc_r + tab;
      end else begin
        x_nxt   = x_r - dx;
        y_nxt   = y_r + dy;
        acc_nxt = acc_r - tab;
      end
      i_nxt = i_r + 1'b1;
      if (i_r == itkf_pkg::TAB_IW'(N - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      i_r    <= i_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    acc_r  <= acc_nxt;
    zero_r <= zero_nxt;
  end

  // Round half up to the output fraction
  assign acc_rnd = (ACC_W+1)'(acc_r) + HALF;
  assign angle   = zero_r ? '0 : itkf_pkg::MEAS_W'(acc_rnd >>> SH);
  assign busy    = busy_r;

endmodule

FILE: rtl/imu_tilt_kalman_filter_top.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake           | Beat content
// in_     | input     | in_valid/in_stall   | accel x/y/z, gyro x/y, elapsed_ms
// out_    | output    | out_valid/out_stall | filtered and gyro roll and pitch
// cfg_    | input     | cfg_valid/cfg_ready | register index and write data
// A sample is taken only in the idle state, so a new sample waits until the last
// result has been handed to the output register; in_stall is high until then.
// The bit-serial dividers for the Kalman gains and the gyro steps take the longest,
// all four running side by side with both CORDIC units; a load step precedes them,
// and a finish step, two update passes and the output hand-off follow them.
// Reset is synchronous, active low, clears filter state and reloads registers.
// A finished beat waits in the output register while out_stall is high; a
// new sample is taken meanwhile but cannot finish until that beat leaves.
module imu_tilt_kalman_filter_top #(
  parameter int FRAC_BITS    = itkf_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = itkf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [15:0]               in_accel_x,
  input  logic signed [15:0]               in_accel_y,
  input  logic signed [15:0]               in_accel_z,
  input  logic signed [15:0]               in_gyro_x,
  input  logic signed [15:0]               in_gyro_y,
  input  logic        [15:0]               in_elapsed_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [24:0]               out_roll_filtered,
  output logic signed [31:0]               out_roll_gyro,
  output logic signed [24:0]               out_pitch_filtered,
  output logic signed [31:0]               out_pitch_gyro,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [itkf_pkg::IDX_W-1:0]       cfg_index,
  input  logic [itkf_pkg::DATA_W-1:0]      cfg_data
);

  `include "imu_tilt_kalman_filter_top_macros.svh"

  localparam int NUM_W  = 32 + FRAC_BITS;
  localparam int K_W    = FRAC_BITS + 1;
  localparam int DIFF_W = itkf_pkg::MEAS_W + 1;
  localparam int PROD_W = DIFF_W + K_W + 1;
  localparam int KP_W   = K_W + 32;
  localparam logic signed [PROD_W:0] HALF_E = (PROD_W+1)'(longint'(1) << (FRAC_BITS - 1));
  localparam logic [KP_W:0] HALF_P = (KP_W+1)'(longint'(1) << (FRAC_BITS - 1));
  localparam logic [K_W-1:0] K_ONE = K_W'(longint'(1) << FRAC_BITS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_RUN  = 6'b000100,
    S_DIFF = 6'b001000,
    S_COV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [itkf_pkg::REG_W-1:0] q_r [2];
  logic [itkf_pkg::REG_W-1:0] r_r [2];
  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r;
  logic [15:0]        ms_r;
  logic signed [31:0] est_r [2];
  logic [31:0]        cov_r [2];
  logic signed [31:0] gang_r [2];
  logic [31:0]        p_r [2];
  logic               dz_r [2];
  logic               gneg_r [2];
  logic [K_W-1:0]     k_r [2];
  logic signed [PROD_W-1:0] prod_r;
  logic               axis_r;
  logic               out_valid_r;
  logic signed [24:0] o_rf_r, o_pf_r;
  logic signed [31:0] o_rg_r, o_pg_r;

  logic in_acc, out_acc, start, units_busy;
  logic [32:0]          pq [2];
  logic [31:0]          p_sat [2];
  logic [itkf_pkg::DEN_W-1:0] den [2];
  logic signed [33:0]   gprod [2];
  logic [31:0]          gmag [2];
  logic [NUM_W-1:0]     gnum [2];
  logic [NUM_W-1:0]     gquo [2];
  logic [NUM_W-1:0]     kquo [2];
  logic                 gbusy [2];
  logic                 kbusy [2];
  logic                 cbusy_r, cbusy_p;
  logic signed [itkf_pkg::MEAS_W-1:0] meas_roll, meas_pitch, meas;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W:0]    est_rnd;
  logic [KP_W:0]             kp_full;
  logic [32:0]               kp;
  logic signed [63:0]        gstep [2];

  assign in_acc     = in_valid && !in_stall;
  assign out_acc    = out_valid_r && !out_stall;
  assign start      = (state_r == S_PREP);
  assign units_busy = gbusy[0] || gbusy[1] || kbusy[0] || kbusy[1] || cbusy_r || cbusy_p;

  // Predicted covariance, gain denominator and gyro dividends
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      pq[a]    = {1'b0, cov_r[a]} + 33'(q_r[a]);
      p_sat[a] = pq[a][32] ? 32'hFFFFFFFF : pq[a][31:0];
      den[a]   = {1'b0, p_sat[a]} + 33'(r_r[a]);
      gprod[a] = 34'($signed(a == 0 ? gx_r : gy_r) * $signed({1'b0, ms_r}));
      gmag[a]  = gprod[a][33] ? 32'(-gprod[a]) : gprod[a][31:0];
      gnum[a]  = (NUM_W'(gmag[a]) << FRAC_BITS) + NUM_W'(itkf_pkg::GYRO_HALF);
      gstep[a] = gneg_r[a] ? -$signed(64'(gquo[a])) : $signed(64'(gquo[a]));
    end
  end

  // Kalman update arithmetic for the selected axis
  always_comb begin
    meas    = axis_r ? meas_pitch : meas_roll;
    diff    = DIFF_W'(meas) - DIFF_W'(est_r[axis_r]);
    est_rnd = ((PROD_W+1)'(prod_r) + HALF_E) >>> FRAC_BITS;
    kp_full = ((KP_W+1)'(k_r[axis_r]) * (KP_W+1)'(p_r[axis_r])) + HALF_P;
    kp      = 33'(kp_full >> FRAC_BITS);
    if (kp > {1'b0, p_r[axis_r]}) kp = {1'b0, p_r[axis_r]};
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_PREP;
      S_PREP: state_nxt = S_RUN;
      S_RUN:  if (!units_busy) state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_COV;
      S_COV:  state_nxt = axis_r ? S_DONE : S_DIFF;
      S_DONE: if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      axis_r      <= 1'b0;
      q_r[0]      <= itkf_pkg::Q_RESET;
      q_r[1]      <= itkf_pkg::Q_RESET;
      r_r[0]      <= itkf_pkg::R_RESET;
      r_r[1]      <= itkf_pkg::R_RESET;
      est_r[0]    <= '0;
      est_r[1]    <= '0;
      cov_r[0]    <= '0;
      cov_r[1]    <= '0;
      gang_r[0]   <= '0;
      gang_r[1]   <= '0;
    end else begin
      state_r <= state_nxt;

      // Register writes
      if (cfg_valid) begin
        unique case (cfg_index)
          itkf_pkg::IDX_W'(itkf_pkg::REG_Q_ROLL):  q_r[0] <= cfg_data[itkf_pkg::REG_W-1:0];
          itkf_pkg::IDX_W'(itkf_pkg::REG_R_ROLL):  r_r[0] <= cfg_data[itkf_pkg::REG_W-1:0];
          itkf_pkg::IDX_W'(itkf_pkg::REG_Q_PITCH): q_r[1] <= cfg_data[itkf_pkg::REG_W-1:0];
          itkf_pkg::IDX_W'(itkf_pkg::REG_R_PITCH): r_r[1] <= cfg_data[itkf_pkg::REG_W-1:0];
          default: ;
        endcase
      end

      // Gyro integration and gain capture once the units finish
      if (state_r == S_RUN && !units_busy) begin
        for (int a = 0; a < 2; a++) begin
          gang_r[a] <= itkf_pkg::clamp32(64'(gang_r[a]) + gstep[a]);
        end
        axis_r <= 1'b0;
      end

      // Estimate and covariance update
      if (state_r == S_COV) begin
        est_r[axis_r] <= itkf_pkg::clamp32(64'(est_r[axis_r]) + 64'(est_rnd));
        cov_r[axis_r] <= 32'({1'b0, p_r[axis_r]} - kp);
        axis_r        <= 1'b1;
      end

      // Output register
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end

    // Payload registers
    if (in_acc) begin
      ax_r <= in_accel_x;
      ay_r <= in_accel_y;
      az_r <= in_accel_z;
      gx_r <= in_gyro_x;
      gy_r <= in_gyro_y;
      ms_r <= in_elapsed_ms;
    end
    if (start) begin
      for (int a = 0; a < 2; a++) begin
        p_r[a]    <= p_sat[a];
        dz_r[a]   <= (den[a] == '0);
        gneg_r[a] <= gprod[a][33];
      end
    end
    if (state_r == S_RUN && !units_busy) begin
      for (int a = 0; a < 2; a++) begin
        k_r[a] <= dz_r[a] ? '0 : kquo[a][K_W-1:0];
      end
    end
    if (state_r == S_DIFF) begin
      prod_r <= PROD_W'(diff * $signed({1'b0, k_r[axis_r]}));
    end
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      o_rf_r <= est_r[0][24:0];
      o_pf_r <= est_r[1][24:0];
      o_rg_r <= gang_r[0];
      o_pg_r <= gang_r[1];
    end
  end

  // Angle units
  itkf_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic_roll (
    .clk(clk), .rst_n(rst_n), .start(start),
    .y_in(17'(ay_r)), .x_in(17'(az_r)),
    .busy(cbusy_r), .angle(meas_roll)
  );

  itkf_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic_pitch (
    .clk(clk), .rst_n(rst_n), .start(start),
    .y_in(-(17'(ax_r))), .x_in(17'(az_r)),
    .busy(cbusy_p), .angle(meas_pitch)
  );

  // Gain and gyro dividers
  for (genvar g = 0; g < 2; g++) begin : g_div
    itkf_sdiv #(.NUM_W(NUM_W), .DEN_W(itkf_pkg::DEN_W)) u_kdiv (
      .clk(clk), .rst_n(rst_n), .start(start),
      .num(NUM_W'(p_sat[g]) << FRAC_BITS), .den(den[g]),
      .busy(kbusy[g]), .quo(kquo[g])
    );
    itkf_sdiv #(.NUM_W(NUM_W), .DEN_W(itkf_pkg::DEN_W)) u_gdiv (
      .clk(clk), .rst_n(rst_n), .start(start),
      .num(gnum[g]), .den(itkf_pkg::DEN_W'(itkf_pkg::GYRO_DIV)),
      .busy(gbusy[g]), .quo(gquo[g])
    );
  end

  assign in_stall           = (state_r != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_roll_filtered  = o_rf_r;
  assign out_pitch_filtered = o_pf_r;
  assign out_roll_gyro      = o_rg_r;
  assign out_pitch_gyro     = o_pg_r;

  `ITKF_ASSERT_NEXT(a_accept_prep, in_acc, state_r == S_PREP, "accepted beat did not start")
  `ITKF_ASSERT_NOW(a_gain_bound, state_r == S_DIFF, k_r[axis_r] <= K_ONE, "gain above one")
  `ITKF_ASSERT_NEXT(a_done_out, state_r == S_DONE && !out_valid_r, out_valid_r,
                    "finished beat not presented")

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import itkf_pkg::*;

  localparam int REG_UNUSED   = 9;
  localparam int DRAIN_CYCLES = 80;
  localparam int HANG_LIMIT   = 5000;

  typedef struct packed {
    logic [24:0] roll_f;
    logic [31:0] roll_g;
    logic [24:0] pitch_f;
    logic [31:0] pitch_g;
  } tilt_beat_t;

  // atan(2^-i) in degrees, 24 fraction bits
  localparam longint ATAN_DEG [16] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335
  };

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic signed [15:0] in_accel_x, in_accel_y, in_accel_z, in_gyro_x, in_gyro_y;
  logic [15:0] in_elapsed_ms;
  logic out_valid, out_stall;
  logic signed [24:0] out_roll_filtered, out_pitch_filtered;
  logic signed [31:0] out_roll_gyro, out_pitch_gyro;
  logic cfg_valid, cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  // Predictor state
  logic [23:0] noise_q_roll, noise_r_roll, noise_q_pitch, noise_r_pitch;
  longint est_roll, est_pitch, gyro_sum_x, gyro_sum_y;
  logic [31:0] cov_roll, cov_pitch;

  tilt_beat_t pending_beats[$];
  int mismatches;
  int send_idle_pct, recv_stall_pct;
  int quiet_cycles;

  imu_tilt_kalman_filter_top i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Vectoring CORDIC, result in degrees Q16.16
  function automatic longint tilt_angle(input longint y_in, input longint x_in);
    longint x, y, acc, t, dx, dy;
    x = x_in * 65536;
    y = y_in * 65536;
    acc = 0;
    if (x_in == 0 && y_in == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        acc = 90 * (64'sd1 << 24);
        t = x; x = y; y = -t;
      end else begin
        acc = -90 * (64'sd1 << 24);
        t = x; x = -y; y = t;
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; acc += ATAN_DEG[i];
      end else begin
        x -= dx; y += dy; acc -= ATAN_DEG[i];
      end
    end
    return (acc + 128) >>> 8;
  endfunction

  // Gyro angle increment, rounded half away from zero
  function automatic longint gyro_increment(input logic signed [15:0] rate,
                                            input logic [15:0] ms);
    longint num, mag;
    num = longint'(rate) * longint'({16'd0, ms}) * 65536;
    mag = (num < 0) ? -num : num;
    mag = (mag + GYRO_HALF) / GYRO_DIV;
    return (num < 0) ? -mag : mag;
  endfunction

  task automatic kalman_update(inout longint est, inout logic [31:0] cov,
                               input logic [23:0] q, input logic [23:0] r,
                               input longint meas);
    longint unsigned p, den, k, kp;
    longint prod;
    p = longint'({32'd0, cov}) + longint'({40'd0, q});
    if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
    den = p + longint'({40'd0, r});
    k = (den != 0) ? (p << 16) / den : 0;
    prod = (meas - est) * longint'(k);
    est = sat32(est + ((prod + 32768) >>> 16));
    kp = (k * p + 32768) >> 16;
    if (kp > p) kp = p;
    cov = 32'(p - kp);
  endtask

  task automatic predict_beat(input logic signed [15:0] ax, ay, az, gx, gy,
                              input logic [15:0] ms);
    tilt_beat_t b;
    longint roll, pitch;
    roll = tilt_angle(longint'(ay), longint'(az));
    pitch = tilt_angle(-longint'(ax), longint'(az));
    gyro_sum_x = sat32(gyro_sum_x + gyro_increment(gx, ms));
    gyro_sum_y = sat32(gyro_sum_y + gyro_increment(gy, ms));
    kalman_update(est_roll, cov_roll, noise_q_roll, noise_r_roll, roll);
    kalman_update(est_pitch, cov_pitch, noise_q_pitch, noise_r_pitch, pitch);
    b.roll_f = est_roll[24:0];
    b.roll_g = gyro_sum_x[31:0];
    b.pitch_f = est_pitch[24:0];
    b.pitch_g = gyro_sum_y[31:0];
    pending_beats.push_back(b);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  // Send one sample beat; entered and left at a falling edge
  task automatic send_sample(input logic signed [15:0] ax, ay, az, gx, gy,
                             input logic [15:0] ms);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_accel_z <= az;
    in_gyro_x <= gx;
    in_gyro_y <= gy;
    in_elapsed_ms <= ms;
    do @(posedge clk); while (in_stall);
    predict_beat(ax, ay, az, gx, gy, ms);
    @(negedge clk);
  endtask

  // Drain, let the pipeline settle, then write one register
  task automatic write_reg(input int idx, input logic [31:0] data);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= IDX_W'(idx);
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_Q_ROLL:  noise_q_roll  = data[23:0];
      REG_R_ROLL:  noise_r_roll  = data[23:0];
      REG_Q_PITCH: noise_q_pitch = data[23:0];
      REG_R_PITCH: noise_r_pitch = data[23:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_noise(input logic [31:0] qr, rr, qp, rp);
    write_reg(REG_Q_ROLL, qr);
    write_reg(REG_R_ROLL, rr);
    write_reg(REG_Q_PITCH, qp);
    write_reg(REG_R_PITCH, rp);
  endtask

  // Quadrant turns, origin, extremes of the accel and elapsed fields
  task automatic test_angle_corners();
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(0, 0, -16384, 100, -100, 10);
    send_sample(-16384, 16384, 0, 0, 0, 5);
    send_sample(16384, -16384, 0, 0, 0, 5);
    send_sample(12000, -9000, -11000, 300, 300, 1);
    send_sample(-32768, 32767, -32768, 0, 0, 0);
    send_sample(32767, -32768, 32767, 0, 0, 65535);
    send_sample(0, 16384, 16384, -500, 500, 20);
    send_sample(-8000, 0, 15000, 1, -1, 1);
  endtask

  // Drive both gyro angles into the positive then negative limit
  task automatic test_gyro_saturation();
    send_sample(100, 200, 16000, 32767, 32767, 65535);
    send_sample(100, 200, 16000, 32767, 32767, 65535);
    send_sample(100, 200, 16000, -32768, -32768, 65535);
    send_sample(100, 200, 16000, -32768, -32768, 65535);
    send_sample(100, 200, 16000, -32768, -32768, 65535);
    send_sample(100, 200, 16000, 16000, -16000, 1000);
  endtask

  // Zero noise: unit gain, then zero denominator holds the estimate
  task automatic test_noise_extremes();
    set_noise(0, 0, 0, 0);
    send_sample(5000, 9000, 14000, 0, 0, 10);
    send_sample(-5000, -9000, 14000, 0, 0, 10);
    send_sample(3000, 3000, -3000, 0, 0, 10);
    set_noise(32'hFFFF_FFFF, 1, 32'hFF00_0000, 24'hFFFFFF);
    send_sample(-7000, 4000, 12000, 10, 10, 10);
    send_sample(7000, -4000, 12000, 10, 10, 10);
    set_noise(0, 24'hFFFFFF, 24'hFFFFFF, 1);
    send_sample(2000, 16000, 2000, 10, 10, 10);
    send_sample(-2000, -16000, -2000, 10, 10, 10);
    write_reg(REG_UNUSED, 32'h0000_1234);
    send_sample(1000, 1000, 16000, 0, 0, 1);
  endtask

  // Mostly plausible tilt samples, a quarter raw noise over every bit
  task automatic test_random_traffic(input int n, input int idle, input int stall);
    logic signed [15:0] ax, ay, az, gx, gy;
    logic [15:0] ms;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 75) begin
        ax = 16'($urandom_range(34000) - 17000);
        ay = 16'($urandom_range(34000) - 17000);
        az = 16'($urandom_range(34000) - 17000);
        gx = 16'($urandom_range(4000) - 2000);
        gy = 16'($urandom_range(4000) - 2000);
        ms = 16'($urandom_range(1, 20));
      end else begin
        ax = 16'($urandom);
        ay = 16'($urandom);
        az = 16'($urandom);
        gx = 16'($urandom);
        gy = 16'($urandom);
        ms = 16'($urandom);
      end
      send_sample(ax, ay, az, gx, gy, ms);
    end
  endtask

  // Receiver stall, driven on the falling edge
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Check each result beat against the oldest prediction; watch for hangs
  always @(posedge clk) begin
    tilt_beat_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready) || pending_beats.size() == 0 && !in_valid)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_beats.size() == 0) begin
          report_mismatch("unexpected beat", out_roll_gyro, 0);
        end else begin
          want = pending_beats.pop_front();
          if (out_roll_filtered !== want.roll_f)
            report_mismatch("roll_filtered", 32'(out_roll_filtered), 32'(want.roll_f));
          if (out_roll_gyro !== want.roll_g)
            report_mismatch("roll_gyro", out_roll_gyro, want.roll_g);
          if (out_pitch_filtered !== want.pitch_f)
            report_mismatch("pitch_filtered", 32'(out_pitch_filtered),
                            32'(want.pitch_f));
          if (out_pitch_gyro !== want.pitch_g)
            report_mismatch("pitch_gyro", out_pitch_gyro, want.pitch_g);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_accel_x = '0; in_accel_y = '0; in_accel_z = '0;
    in_gyro_x = '0; in_gyro_y = '0; in_elapsed_ms = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    mismatches = 0; quiet_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    noise_q_roll = Q_RESET; noise_r_roll = R_RESET;
    noise_q_pitch = Q_RESET; noise_r_pitch = R_RESET;
    est_roll = 0; est_pitch = 0; cov_roll = 0; cov_pitch = 0;
    gyro_sum_x = 0; gyro_sum_y = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_angle_corners();
    test_gyro_saturation();
    test_noise_extremes();
    set_noise(Q_RESET, R_RESET, Q_RESET, R_RESET);
    test_random_traffic(600, 29, 61);
    set_noise($urandom_range(24'hFFFFFF), $urandom_range(1, 24'hFFFFFF),
              $urandom_range(24'hFFFFFF), $urandom_range(1, 24'hFFFFFF));
    test_random_traffic(600, 61, 29);
    set_noise($urandom_range(0, 24'h3FFFF), $urandom_range(1, 24'h3FFFFF),
              $urandom, $urandom);
    test_random_traffic(600, 0, 0);

    // Drain and let the last beat settle
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
